/* design/weekly_setpoint_scheduler_top_defines.svh */
// ----------------------------------------------------------------------------
// Weekly setpoint scheduler assertion macros
// Shared property wrappers used by the port checker of the scheduler.
// ----------------------------------------------------------------------------
`ifndef WEEKLY_SETPOINT_SCHEDULER_TOP_DEFINES_SVH
`define WEEKLY_SETPOINT_SCHEDULER_TOP_DEFINES_SVH

// Property sampled on the clock and switched off while reset is asserted.
`define WSS_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property sampled on the clock at every edge, reset included.
`define WSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/wss_pkg.sv */
// ----------------------------------------------------------------------------
// Weekly setpoint scheduler package
// Types, codes and helper functions shared by the scheduler modules.
// ----------------------------------------------------------------------------
package wss_pkg;

  localparam int ENTRIES = 128;
  localparam int PTR_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int IDX_W   = 7;
  localparam int CW      = ((PTR_W > IDX_W) ? PTR_W : IDX_W) + 1;
  localparam int KEY_W   = 14;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TIME = 1'b1;

  localparam logic [2:0] DAY_SUNDAY_IN = 3'd0;
  localparam logic [2:0] DAY_SUNDAY    = 3'd7;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CW-1:0]    cmp_t;
  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic [2:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [7:0] value;
  } entry_t;

  typedef struct packed {
    logic   en;
    entry_t data;
  } ring_wr_t;

  typedef struct packed {
    ptr_t   idx;
    entry_t data;
  } ring_head_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  typedef enum logic [1:0] {
    STAT_KEEP    = 2'd0,
    STAT_STEP    = 2'd1,
    STAT_RELOC   = 2'd2,
    STAT_INVALID = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ORD_BEFORE,
    ORD_EQUAL,
    ORD_AFTER
  } order_t;

  function automatic key_t entry_key(entry_t e);
    return {e.day, e.hour, e.minute};
  endfunction

  function automatic order_t key_order(key_t now_k, key_t ref_k);
    if (now_k < ref_k) begin
      return ORD_BEFORE;
    end else if (now_k > ref_k) begin
      return ORD_AFTER;
    end
    return ORD_EQUAL;
  endfunction

  function automatic cmp_t widen_ptr(ptr_t p);
    return CW'(p);
  endfunction

  function automatic cmp_t widen_idx(idx_t i);
    return CW'(i);
  endfunction

endpackage

/* design/weekly_setpoint_scheduler_top.sv */
// A valid time transaction is scanned over one full turn of the programme ring past the
// comparison head and is then decided in the decision state before its result is offered.
// One transaction at a time: the next is taken once the block is idle again, after the scan
// and decision for a valid time, the decision for an invalid time or a load's slot write.
// A result still stalled at the output holds back the next decision and the input.
// Reset is synchronous: indices return to 0 and 1, last_index to 0; entries stay undefined.
// ----------------------------------------------------------------------------
// Weekly setpoint scheduler
// Holds a sorted weekly programme and decides the setpoint for each time point.
// ----------------------------------------------------------------------------
module weekly_setpoint_scheduler_top import wss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              req_type,
  input  logic [6:0]        entry_index,
  input  logic [2:0]        entry_day,
  input  logic [4:0]        entry_hour,
  input  logic [5:0]        entry_minute,
  input  logic signed [7:0] entry_value,
  input  logic [2:0]        now_day,
  input  logic [4:0]        now_hour,
  input  logic [5:0]        now_minute,
  input  logic              time_valid,
  input  logic              override_on,
  input  logic signed [7:0] override_value,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [6:0]        cfg_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic signed [7:0] setpoint,
  output logic              override_still_on,
  output logic [6:0]        prev_index_out,
  output logic [6:0]        next_index_out
);

  ring_wr_t   ring_wr;
  ring_head_t ring_head;

  wss_ring u_ring (
    .clk  (clk),
    .rst  (rst),
    .wr   (ring_wr),
    .head (ring_head)
  );

  wss_ctrl u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .req_type          (req_type),
    .entry_index       (entry_index),
    .entry_day         (entry_day),
    .entry_hour        (entry_hour),
    .entry_minute      (entry_minute),
    .entry_value       (entry_value),
    .now_day           (now_day),
    .now_hour          (now_hour),
    .now_minute        (now_minute),
    .time_valid        (time_valid),
    .override_on       (override_on),
    .override_value    (override_value),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .setpoint          (setpoint),
    .override_still_on (override_still_on),
    .prev_index_out    (prev_index_out),
    .next_index_out    (next_index_out),
    .wr                (ring_wr),
    .head              (ring_head)
  );

endmodule

/* design/wss_cell.sv */
// ----------------------------------------------------------------------------
// Scheduler ring cell
// Holds one programme entry and passes it to its neighbour every cycle.
// ----------------------------------------------------------------------------
module wss_cell import wss_pkg::*; (
  input  logic   clk,
  input  entry_t shift_in,
  input  logic   load,
  input  entry_t load_data,
  output entry_t data
);

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end else begin
      data <= shift_in;
    end
  end

endmodule

/* design/wss_ring.sv */
// ----------------------------------------------------------------------------
// Scheduler programme ring
// A closed chain of entry cells that rotates by one slot per cycle.
// ----------------------------------------------------------------------------
module wss_ring import wss_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ring_wr_t   wr,
  output ring_head_t head
);

  entry_t cells [ENTRIES];
  ptr_t   head_idx;

  // The entry leaving the head re-enters at the tail, or is replaced there.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == ENTRIES - 1) begin : g_tail
      wss_cell u_cell (
        .clk       (clk),
        .shift_in  (cells[0]),
        .load      (wr.en),
        .load_data (wr.data),
        .data      (cells[i])
      );
    end else begin : g_body
      wss_cell u_cell (
        .clk       (clk),
        .shift_in  (cells[i+1]),
        .load      (1'b0),
        .load_data (wr.data),
        .data      (cells[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_idx <= '0;
    end else if (head_idx == PTR_W'(ENTRIES - 1)) begin
      head_idx <= '0;
    end else begin
      head_idx <= head_idx + PTR_W'(1);
    end
  end

  assign head = '{idx: head_idx, data: cells[0]};

endmodule

/* design/wss_ctrl.sv */
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences loads and evaluations, scans the ring and registers the result.
// ----------------------------------------------------------------------------
module wss_ctrl import wss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              req_type,
  input  logic [6:0]        entry_index,
  input  logic [2:0]        entry_day,
  input  logic [4:0]        entry_hour,
  input  logic [5:0]        entry_minute,
  input  logic signed [7:0] entry_value,
  input  logic [2:0]        now_day,
  input  logic [4:0]        now_hour,
  input  logic [5:0]        now_minute,
  input  logic              time_valid,
  input  logic              override_on,
  input  logic signed [7:0] override_value,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [6:0]        cfg_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic signed [7:0] setpoint,
  output logic              override_still_on,
  output logic [6:0]        prev_index_out,
  output logic [6:0]        next_index_out,
  output ring_wr_t          wr,
  input  ring_head_t        head
);

  state_t     state;
  state_t     state_next;
  idx_t       last_index;
  idx_t       prev_entry;
  idx_t       next_entry;
  ptr_t       scan_cnt;
  logic       found;
  idx_t       found_idx;

  key_t       now_key;
  logic       ov_on_r;
  logic [7:0] ov_val_r;
  logic       inv_r;
  idx_t       ld_idx;
  entry_t     ld_entry;
  key_t       prev_key;
  logic [7:0] prev_val;
  key_t       next_key;
  logic [7:0] step_val;
  logic [7:0] zero_val;

  logic       take;
  logic       scanning;
  logic       fire;
  logic       load_ok;
  logic       load_hit;
  logic       scan_last;
  logic       scan_take;
  logic [2:0] day_fix;
  key_t       head_key;
  cmp_t       head_w;
  idx_t       lim;
  cmp_t       lim_w;
  cmp_t       prev_w;
  cmp_t       prev_inc;
  cmp_t       nxt_w;
  cmp_t       step_p;
  cmp_t       step_n;
  idx_t       nxt;
  order_t     p1;
  order_t     p2;
  status_t    dec_status;
  logic [7:0] dec_target;
  logic       dec_ov;
  idx_t       dec_prev;
  idx_t       dec_next;

  assign cfg_ready = 1'b1;
  assign lim       = (widen_idx(last_index) < CW'(ENTRIES - 1)) ? last_index
                                                                : IDX_W'(ENTRIES - 1);
  assign lim_w     = widen_idx(lim);
  assign day_fix   = (now_day == DAY_SUNDAY_IN) ? DAY_SUNDAY : now_day;
  assign head_key  = entry_key(head.data);
  assign head_w    = widen_ptr(head.idx);
  assign load_ok   = widen_idx(entry_index) < CW'(ENTRIES);
  assign load_hit  = head_w == widen_idx(ld_idx);
  assign scan_last = scan_cnt == PTR_W'(ENTRIES - 1);
  assign scan_take = (head_w <= lim_w) && (key_order(now_key, head_key) != ORD_AFTER)
                     && (!found || (head_w < widen_idx(found_idx)));

  always_comb begin : next_state_logic
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_LOAD) begin
            if (load_ok) begin
              state_next = ST_LOAD;
            end
          end else if (time_valid) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DECIDE;
          end
        end
      end
      ST_LOAD: begin
        if (load_hit) begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin : output_logic
    in_stall = 1'b1;
    take     = 1'b0;
    scanning = 1'b0;
    fire     = 1'b0;
    wr.en    = 1'b0;
    wr.data  = ld_entry;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        take     = in_valid;
      end
      ST_LOAD: begin
        wr.en = load_hit;
      end
      ST_SCAN: begin
        scanning = 1'b1;
      end
      ST_DECIDE: begin
        fire = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin : decide_logic
    prev_w   = widen_idx(prev_entry);
    prev_inc = prev_w + CW'(1);
    p1       = key_order(now_key, prev_key);
    if (prev_w < lim_w) begin
      p2  = key_order(now_key, next_key);
      nxt = next_entry;
    end else begin
      p2  = ORD_BEFORE;
      nxt = '0;
    end
    nxt_w = widen_idx(nxt);

    if (nxt_w == lim_w) begin
      step_p = prev_inc;
      step_n = '0;
    end else if (prev_w == lim_w) begin
      step_p = '0;
      step_n = CW'(1);
    end else begin
      step_p = prev_inc;
      step_n = nxt_w + CW'(1);
    end
    if (step_p > lim_w) begin
      step_p = '0;
    end
    if (step_n > lim_w) begin
      step_n = '0;
    end

    dec_status = STAT_INVALID;
    dec_target = '0;
    dec_ov     = ov_on_r;
    dec_prev   = prev_entry;
    dec_next   = next_entry;
    if (inv_r) begin
      dec_status = STAT_INVALID;
    end else if ((p1 == ORD_EQUAL) || ((p1 == ORD_AFTER) && (p2 == ORD_BEFORE))) begin
      dec_status = STAT_KEEP;
      dec_target = ov_on_r ? ov_val_r : prev_val;
      dec_next   = nxt;
    end else if (p2 == ORD_EQUAL) begin
      dec_status = STAT_STEP;
      dec_prev   = IDX_W'(step_p);
      dec_next   = IDX_W'(step_n);
      dec_ov     = 1'b0;
      dec_target = (step_p == '0) ? zero_val : step_val;
    end else begin
      dec_status = STAT_RELOC;
      if (found) begin
        dec_prev = (found_idx == '0) ? lim : found_idx - IDX_W'(1);
        dec_next = found_idx;
      end else begin
        dec_prev = lim;
        dec_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      last_index <= '0;
      prev_entry <= '0;
      next_entry <= IDX_W'(1);
      out_valid  <= 1'b0;
      found      <= 1'b0;
      scan_cnt   <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        last_index <= cfg_data;
      end
      if (fire) begin
        prev_entry <= dec_prev;
        next_entry <= dec_next;
        out_valid  <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        found    <= 1'b0;
        scan_cnt <= '0;
      end else if (scanning) begin
        scan_cnt <= scan_cnt + PTR_W'(1);
        if (scan_take) begin
          found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      now_key   <= {day_fix, now_hour, now_minute};
      ov_on_r   <= override_on;
      ov_val_r  <= override_value;
      inv_r     <= (req_type == REQ_TIME) && !time_valid;
      ld_idx    <= entry_index;
      ld_entry  <= '{day: entry_day, hour: entry_hour, minute: entry_minute,
                     value: entry_value};
      prev_key  <= '0;
      prev_val  <= '0;
      next_key  <= '0;
      step_val  <= '0;
      zero_val  <= '0;
      found_idx <= '0;
    end else if (scanning) begin
      if (head_w == widen_idx(prev_entry)) begin
        prev_key <= head_key;
        prev_val <= head.data.value;
      end
      if (head_w == widen_idx(next_entry)) begin
        next_key <= head_key;
      end
      if (head_w == prev_inc) begin
        step_val <= head.data.value;
      end
      if (head_w == '0) begin
        zero_val <= head.data.value;
      end
      if (scan_take) begin
        found_idx <= IDX_W'(head.idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status            <= dec_status;
      setpoint          <= dec_target;
      override_still_on <= dec_ov;
      prev_index_out    <= dec_prev;
      next_index_out    <= dec_next;
    end
  end

endmodule

/* design/wss_checker.sv */
// ----------------------------------------------------------------------------
// Weekly setpoint scheduler port checker
// Watches the top-level ports and flags results that break the block's rules.
// ----------------------------------------------------------------------------
`include "weekly_setpoint_scheduler_top_defines.svh"

module wss_checker import wss_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        status,
  input logic signed [7:0] setpoint,
  input logic              override_still_on,
  input logic [6:0]        prev_index_out,
  input logic [6:0]        next_index_out
);

  property p_out_hold;
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(setpoint)
      && $stable(override_still_on) && $stable(prev_index_out) && $stable(next_index_out);
  endproperty

  property p_zero_target;
    out_valid && (status == STAT_RELOC || status == STAT_INVALID) |-> setpoint == 8'sd0;
  endproperty

  property p_step_clears;
    out_valid && status == STAT_STEP |-> !override_still_on;
  endproperty

  `WSS_ASSERT_RUN(a_out_hold, p_out_hold, "Stalled result transaction changed")
  `WSS_ASSERT_RUN(a_zero_target, p_zero_target, "Relocation or invalid time with a setpoint")
  `WSS_ASSERT_RUN(a_step_clears, p_step_clears, "Transition left the override on")
  `WSS_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !out_valid, "Result offered after reset")

endmodule

bind weekly_setpoint_scheduler_top wss_checker u_wss_checker (.*);

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weekly setpoint scheduler testbench
// Loads sorted weekly programmes, walks time points through them and checks
// every result against a cycle-free prediction, under random idling on both
// channels, a long output hold-off and several last_index settings.
// ----------------------------------------------------------------------------
module tb_top;
  import wss_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 7;
  localparam int TAIL_CYCLES    = ENTRIES + 12;
  localparam int HOLD_CYCLES    = 2000;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int ITEM_TARGET    = 1450;
  localparam int MAX_GAP        = 6;
  localparam int REPORT_LINES   = 100;
  localparam int DAY_MINUTES    = 1440;
  localparam int WEEK_MINUTES   = 7 * DAY_MINUTES;

  typedef struct {
    logic              req_type;
    logic [6:0]        entry_index;
    logic [2:0]        entry_day;
    logic [4:0]        entry_hour;
    logic [5:0]        entry_minute;
    logic signed [7:0] entry_value;
    logic [2:0]        now_day;
    logic [4:0]        now_hour;
    logic [5:0]        now_minute;
    logic              time_valid;
    logic              override_on;
    logic signed [7:0] override_value;
  } sched_req_t;

  typedef struct {
    status_t           status;
    logic signed [7:0] target;
    logic              ovr;
    logic [6:0]        force_slot;
    logic [6:0]        due_slot;
  } setpoint_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              req_type;
  logic [6:0]        entry_index;
  logic [2:0]        entry_day;
  logic [4:0]        entry_hour;
  logic [5:0]        entry_minute;
  logic signed [7:0] entry_value;
  logic [2:0]        now_day;
  logic [4:0]        now_hour;
  logic [5:0]        now_minute;
  logic              time_valid;
  logic              override_on;
  logic signed [7:0] override_value;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [6:0]        cfg_data;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        status;
  logic signed [7:0] setpoint;
  logic              override_still_on;
  logic [6:0]        prev_index_out;
  logic [6:0]        next_index_out;

  entry_t      programme [ENTRIES];
  int unsigned in_force_idx = 0;
  int unsigned pending_idx  = 1;
  int unsigned last_slot    = 0;
  setpoint_t   pending_setpoints [$];

  int plan_min [ENTRIES];
  int items_sent     = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int hold_request   = 0;
  bit src_idle       = 1'b1;
  bit sink_idle      = 1'b1;

  weekly_setpoint_scheduler_top dut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [14:0] slot_key(int unsigned idx);
    entry_t e;
    e = programme[ptr_t'(idx)];
    return {1'b0, e.day, e.hour, e.minute};
  endfunction

  function automatic bit predict_setpoint(input sched_req_t r, output setpoint_t res);
    int unsigned lim;
    int unsigned i;
    logic [2:0]  d;
    logic [14:0] now_k;
    logic [14:0] pk;
    logic [14:0] nk;
    lim = last_slot;
    res.ovr = r.override_on;
    res.target = '0;
    if (r.req_type == REQ_LOAD) begin
      if (r.entry_index < ENTRIES) begin
        programme[r.entry_index].day    = r.entry_day;
        programme[r.entry_index].hour   = r.entry_hour;
        programme[r.entry_index].minute = r.entry_minute;
        programme[r.entry_index].value  = r.entry_value;
      end
      return 1'b0;
    end
    if (!r.time_valid) begin
      res.status = STAT_INVALID;
    end else begin
      d = (r.now_day == DAY_SUNDAY_IN) ? DAY_SUNDAY : r.now_day;
      now_k = {1'b0, d, r.now_hour, r.now_minute};
      pk = slot_key(in_force_idx);
      if (in_force_idx < lim) begin
        nk = slot_key(pending_idx);
      end else begin
        // Past the last entry the pending one is the first entry of next week.
        pending_idx = 0;
        nk = {4'd8, programme[0].hour, programme[0].minute};
      end
      if (now_k == pk || (now_k > pk && now_k < nk)) begin
        res.status = STAT_KEEP;
        res.target = r.override_on ? r.override_value
                                   : programme[ptr_t'(in_force_idx)].value;
      end else if (now_k == nk) begin
        if (pending_idx == lim) begin
          in_force_idx++;
          pending_idx = 0;
        end else if (in_force_idx == lim) begin
          in_force_idx = 0;
          pending_idx = 1;
        end else begin
          in_force_idx++;
          pending_idx++;
        end
        if (in_force_idx > lim) in_force_idx = 0;
        if (pending_idx > lim) pending_idx = 0;
        res.status = STAT_STEP;
        res.ovr = 1'b0;
        res.target = programme[ptr_t'(in_force_idx)].value;
      end else begin
        i = 0;
        while (i <= lim && slot_key(i) < now_k) i++;
        if (i > lim) begin
          in_force_idx = lim;
          pending_idx = 0;
        end else begin
          in_force_idx = (i == 0) ? lim : i - 1;
          pending_idx = i;
        end
        res.status = STAT_RELOC;
      end
    end
    res.force_slot = in_force_idx[6:0];
    res.due_slot   = pending_idx[6:0];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < REPORT_LINES) $display("[%0t] setpoint check: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : capture_item
    sched_req_t seen;
    setpoint_t  want;
    if (!rst && in_valid && !in_stall) begin
      seen = '{req_type, entry_index, entry_day, entry_hour, entry_minute, entry_value,
               now_day, now_hour, now_minute, time_valid, override_on, override_value};
      if (predict_setpoint(seen, want)) pending_setpoints.push_back(want);
    end
  end

  always @(posedge clk) begin : check_result
    setpoint_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_setpoints.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = pending_setpoints.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (setpoint !== want.target)
          report_mismatch($sformatf("setpoint %0d, expected %0d", setpoint, want.target));
        if (override_still_on !== want.ovr)
          report_mismatch($sformatf("override_still_on %0b, expected %0b",
                                    override_still_on, want.ovr));
        if (prev_index_out !== want.force_slot)
          report_mismatch($sformatf("prev_index_out %0d, expected %0d", prev_index_out,
                                    want.force_slot));
        if (next_index_out !== want.due_slot)
          report_mismatch($sformatf("next_index_out %0d, expected %0d", next_index_out,
                                    want.due_slot));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_sink
    int wait_n;
    out_stall = 1'b0;
    forever begin
      wait_n = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (hold_request > 0) begin
        wait_n = hold_request;
        hold_request = 0;
      end
      if (wait_n > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (wait_n - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  function automatic sched_req_t random_item();
    sched_req_t it;
    it.req_type       = 1'($urandom_range(0, 1));
    it.entry_index    = 7'($urandom_range(0, ENTRIES - 1));
    it.entry_day      = 3'($urandom_range(1, 7));
    it.entry_hour     = 5'($urandom_range(0, 23));
    it.entry_minute   = 6'($urandom_range(0, 59));
    it.entry_value    = 8'($urandom_range(0, 255));
    it.now_day        = 3'($urandom_range(0, 6));
    it.now_hour       = 5'($urandom_range(0, 23));
    it.now_minute     = 6'($urandom_range(0, 59));
    it.time_valid     = 1'($urandom_range(0, 1));
    it.override_on    = 1'($urandom_range(0, 1));
    it.override_value = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic sched_req_t time_item(int m);
    sched_req_t it;
    it = random_item();
    it.req_type   = REQ_TIME;
    it.time_valid = 1'b1;
    it.now_day    = 3'(m / DAY_MINUTES + 1);
    if (it.now_day == DAY_SUNDAY && $urandom_range(0, 1)) it.now_day = DAY_SUNDAY_IN;
    it.now_hour   = 5'((m % DAY_MINUTES) / 60);
    it.now_minute = 6'(m % 60);
    return it;
  endfunction

  function automatic sched_req_t load_item(int slot, int m, int v);
    sched_req_t it;
    it = random_item();
    it.req_type     = REQ_LOAD;
    it.entry_index  = 7'(slot);
    it.entry_day    = 3'(m / DAY_MINUTES + 1);
    it.entry_hour   = 5'((m % DAY_MINUTES) / 60);
    it.entry_minute = 6'(m % 60);
    it.entry_value  = 8'(v);
    plan_min[ptr_t'(slot)] = m;
    return it;
  endfunction

  task automatic send_item(input sched_req_t it);
    int gap;
    gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    req_type       <= it.req_type;
    entry_index    <= it.entry_index;
    entry_day      <= it.entry_day;
    entry_hour     <= it.entry_hour;
    entry_minute   <= it.entry_minute;
    entry_value    <= it.entry_value;
    now_day        <= it.now_day;
    now_hour       <= it.now_hour;
    now_minute     <= it.now_minute;
    time_valid     <= it.time_valid;
    override_on    <= it.override_on;
    override_value <= it.override_value;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_setpoints.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_last_index(input int v);
    quiesce();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= 7'(v);
    do @(posedge clk); while (!cfg_ready);
    last_slot = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_programme(input int count);
    int stride;
    stride = WEEK_MINUTES / count;
    for (int k = 0; k < count; k++)
      send_item(load_item(k, k * stride + $urandom_range(0, stride - 1),
                          $urandom_range(0, 255)));
  endtask

  task automatic test_programme_fill();
    load_programme(ENTRIES);
    send_item(load_item(0, 0, -128));
    send_item(load_item(ENTRIES - 1, WEEK_MINUTES - 1, 127));
  endtask

  task automatic test_directed_steps();
    sched_req_t it;
    set_last_index(3);
    it = time_item(100);
    it.time_valid = 1'b0;
    it.override_on = 1'b1;
    it.override_value = 8'(127);
    send_item(it);
    it = time_item(plan_min[0]);
    it.override_on = 1'b0;
    send_item(it);
    it = time_item(plan_min[1] - 1);
    it.override_on = 1'b1;
    it.override_value = 8'(-128);
    send_item(it);
    it = time_item(plan_min[1]);
    it.override_on = 1'b1;
    send_item(it);
    send_item(time_item(plan_min[2]));
    send_item(time_item(plan_min[3]));
    it = time_item(WEEK_MINUTES - 1);
    it.now_day = DAY_SUNDAY_IN;
    it.override_on = 1'b1;
    send_item(it);
    it.now_day = DAY_SUNDAY;
    it.override_on = 1'b0;
    send_item(it);
    send_item(time_item(plan_min[0]));
    send_item(time_item(plan_min[1]));
    send_item(time_item(WEEK_MINUTES - 1));
    it = random_item();
    it.req_type = REQ_TIME;
    it.time_valid = 1'b0;
    send_item(it);
    set_last_index(0);
    send_item(time_item(plan_min[0]));
    send_item(time_item(WEEK_MINUTES - 1));
    send_item(time_item($urandom_range(0, WEEK_MINUTES - 1)));
  endtask

  task automatic test_last_index_extremes();
    set_last_index(ENTRIES - 1);
    for (int k = 0; k < ENTRIES + 90; k++)
      send_item(time_item(plan_min[ptr_t'(k % ENTRIES)]));
    // The indices now point well past the new last entry.
    set_last_index(5);
    for (int k = 0; k < 7; k++) send_item(time_item(plan_min[ptr_t'(k)]));
    send_item(time_item($urandom_range(0, WEEK_MINUTES - 1)));
  endtask

  task automatic test_output_backpressure();
    src_idle = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (24) send_item(time_item($urandom_range(0, WEEK_MINUTES - 1)));
    src_idle = 1'b1;
  endtask

  task automatic test_random_walks();
    int pick;
    int last;
    int walk;
    int m;
    sched_req_t it;
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) last = 0;
      else if (pick == 1) last = ENTRIES - 1;
      else if (pick < 6) last = $urandom_range(1, 8);
      else last = $urandom_range(1, ENTRIES - 2);
      src_idle  = $urandom_range(0, 3) != 0;
      sink_idle = $urandom_range(0, 3) != 0;
      set_last_index(last);
      if ($urandom_range(0, 3) != 0) load_programme(last + 1);
      walk = $urandom_range(0, last);
      repeat ($urandom_range(20, 60)) begin
        pick = $urandom_range(0, 19);
        if (pick < 10) begin
          send_item(time_item(plan_min[ptr_t'(walk)]));
          walk = (walk == last) ? 0 : walk + 1;
        end else if (pick < 14) begin
          m = plan_min[ptr_t'(walk)] - $urandom_range(1, 3);
          send_item(time_item(m < 0 ? 0 : m));
        end else if (pick < 16) begin
          send_item(time_item($urandom_range(0, WEEK_MINUTES - 1)));
        end else if (pick < 19) begin
          it = random_item();
          it.req_type = REQ_TIME;
          it.time_valid = 1'b0;
          send_item(it);
        end else begin
          send_item(load_item($urandom_range(0, ENTRIES - 1),
                              $urandom_range(0, WEEK_MINUTES - 1), $urandom_range(0, 255)));
        end
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    req_type       = REQ_LOAD;
    entry_index    = '0;
    entry_day      = 3'd1;
    entry_hour     = '0;
    entry_minute   = '0;
    entry_value    = '0;
    now_day        = '0;
    now_hour       = '0;
    now_minute     = '0;
    time_valid     = 1'b0;
    override_on    = 1'b0;
    override_value = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    test_programme_fill();
    test_directed_steps();
    test_last_index_extremes();
    test_output_backpressure();
    test_random_walks();
    quiesce();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
